>>> sv/bpc_pkg.sv
// Package with the shared constants and helper functions of the pressure compensation block.
package bpc_pkg;

    localparam int RawWidth   = 24;
    localparam int MagWidth   = 27;
    localparam int ScaledWidth = 28;
    localparam int RecipWidth = 32;
    localparam int RecipShift = 32;
    localparam int DivWidth   = 8;
    localparam int CfgCount   = 8;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 32;

    localparam logic [2:0] REG_OSR_SELECT    = 3'd0;
    localparam logic [2:0] REG_TEMP_COEFFS   = 3'd1;
    localparam logic [2:0] REG_PRESS_OFFSET  = 3'd2;
    localparam logic [2:0] REG_PRESS_LINEAR  = 3'd3;
    localparam logic [2:0] REG_TEMP_CROSS    = 3'd4;
    localparam logic [2:0] REG_CROSS_LINEAR  = 3'd5;
    localparam logic [2:0] REG_CROSS_SQUARE  = 3'd6;
    localparam logic [2:0] REG_PRESS_HIGH    = 3'd7;

    // Each scale factor is (2^n - 1) * 2^s; s is 19 for the low four codes and 13 for the rest.
    function automatic logic [DivWidth-1:0] divisor(input logic [2:0] code);
        logic [DivWidth-1:0] d;
        begin
            case (code)
                3'd0: d = 8'd1;
                3'd1: d = 8'd3;
                3'd2: d = 8'd7;
                3'd3: d = 8'd15;
                3'd4: d = 8'd31;
                3'd5: d = 8'd63;
                3'd6: d = 8'd127;
                3'd7: d = 8'd255;
                default: d = 8'd1;
            endcase
            return d;
        end
    endfunction

    // floor(2^32 / divisor); unused for divisor one, which bypasses the multiply.
    function automatic logic [RecipWidth-1:0] recip(input logic [2:0] code);
        logic [RecipWidth-1:0] r;
        begin
            case (code)
                3'd0: r = 32'd0;
                3'd1: r = 32'd1431655765;
                3'd2: r = 32'd613566756;
                3'd3: r = 32'd286331153;
                3'd4: r = 32'd138547332;
                3'd5: r = 32'd68174084;
                3'd6: r = 32'd33818640;
                3'd7: r = 32'd16843009;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic [5:0]         osr_select;
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c21;
        logic signed [15:0] c20;
        logic signed [15:0] c30;
    } coeff_t;

endpackage

>>> sv/bpc_in_if.sv
// Interface carrying one raw pressure and temperature reading pair.
interface bpc_in_if;
    logic              valid;
    logic              ready;
    logic signed [23:0] raw_pressure;
    logic signed [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

>>> sv/bpc_out_if.sv
// Interface carrying one compensated pressure and temperature result.
interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] comp_pressure;
    logic signed [31:0] comp_temperature;

    modport source (output valid, output comp_pressure, output comp_temperature, input ready);
    modport sink   (input valid, input comp_pressure, input comp_temperature, output ready);
endinterface

>>> sv/bpc_scaler.sv
// Two-stage oversampling scaler: reading times 2^16 divided by the table factor, toward zero.
module bpc_scaler
(
    input  logic                                   clk,
    input  logic                                   advance,
    input  logic signed [bpc_pkg::RawWidth-1:0]    raw,
    input  logic [2:0]                             code,
    output logic signed [bpc_pkg::ScaledWidth-1:0] scaled
);

    localparam int ProdWidth = bpc_pkg::MagWidth + bpc_pkg::RecipWidth;

    logic [bpc_pkg::RawWidth-1:0]  mag;
    logic [bpc_pkg::MagWidth-1:0]  dividend;
    logic [ProdWidth-1:0]          prod_next;
    logic [ProdWidth-1:0]          prod_reg;
    logic [bpc_pkg::MagWidth-1:0]  dividend_reg;
    logic [2:0]                    code_reg;
    logic                          neg_reg;
    logic [bpc_pkg::MagWidth-1:0]  quot_est;
    logic [bpc_pkg::MagWidth+bpc_pkg::DivWidth-1:0] back_prod;
    logic [bpc_pkg::MagWidth-1:0]  remainder;
    logic [bpc_pkg::MagWidth-1:0]  quot;
    logic signed [bpc_pkg::ScaledWidth-1:0] scaled_next;
    logic signed [bpc_pkg::ScaledWidth-1:0] scaled_reg;

    always_comb
    begin
        mag = raw[bpc_pkg::RawWidth-1] ? bpc_pkg::RawWidth'(-raw) : bpc_pkg::RawWidth'(raw);
        // The power-of-two part of the factor against the 2^16 scale is a fixed shift.
        if (code[2])
        begin
            dividend = {mag, 3'b000};
        end
        else
        begin
            dividend = bpc_pkg::MagWidth'(mag >> 3);
        end
        prod_next = ProdWidth'(dividend) * ProdWidth'(bpc_pkg::recip(code));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg     <= prod_next;
            dividend_reg <= dividend;
            code_reg     <= code;
            neg_reg      <= raw[bpc_pkg::RawWidth-1];
            scaled_reg   <= scaled_next;
        end
    end

    always_comb
    begin
        // The reciprocal estimate is low by at most one; one compare fixes it.
        quot_est  = bpc_pkg::MagWidth'(prod_reg >> bpc_pkg::RecipShift);
        back_prod = (bpc_pkg::MagWidth + bpc_pkg::DivWidth)'(quot_est)
                  * (bpc_pkg::MagWidth + bpc_pkg::DivWidth)'(bpc_pkg::divisor(code_reg));
        remainder = dividend_reg - bpc_pkg::MagWidth'(back_prod);
        if (code_reg == 3'd0)
        begin
            quot = dividend_reg;
        end
        else if (remainder >= bpc_pkg::MagWidth'(bpc_pkg::divisor(code_reg)))
        begin
            quot = quot_est + bpc_pkg::MagWidth'(1);
        end
        else
        begin
            quot = quot_est;
        end
        scaled_next = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    assign scaled = scaled_reg;

endmodule

>>> sv/bpc_poly.sv
// Pipelined evaluation of the calibration polynomial with an output register.
module bpc_poly
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   valid_in,
    input  bpc_pkg::coeff_t                        coeff,
    input  logic signed [bpc_pkg::ScaledWidth-1:0] ps,
    input  logic signed [bpc_pkg::ScaledWidth-1:0] ts,
    output logic                                   valid_out,
    output logic signed [31:0]                     comp_pressure,
    output logic signed [31:0]                     comp_temperature
);

    localparam int WideWidth = 32 + bpc_pkg::ScaledWidth;

    logic [5:0] valid_reg;

    // Stage C: the four narrow products.
    logic signed [31:0] pr_c30_reg, pr_c21_reg, pr_c01_reg, pr_c1_reg;
    logic signed [bpc_pkg::ScaledWidth-1:0] ps_c_reg, ts_c_reg;
    logic signed [43:0] pr_c30, pr_c21, pr_c01;
    logic signed [39:0] pr_c1;

    // Stage D: second-order terms and temperature sum.
    logic signed [31:0] q2a_reg, q2b_reg, t_reg, pt3_d_reg;
    logic signed [bpc_pkg::ScaledWidth-1:0] ps_d_reg, ts_d_reg;

    // Stage E: wide products.
    logic signed [WideWidth-1:0] m1, m2;
    logic signed [31:0] m1_reg, m2_reg, t100_reg, pt3_e_reg;
    logic signed [bpc_pkg::ScaledWidth-1:0] ps_e_reg, ts_e_reg;

    // Stage F: third-order terms and temperature result.
    logic signed [31:0] q3a_reg, q3b_reg, temp_f_reg, pt3_f_reg;
    logic signed [bpc_pkg::ScaledWidth-1:0] ps_f_reg, ts_f_reg;
    logic signed [31:0] t100_adj;

    // Stage G: last wide products.
    logic signed [WideWidth-1:0] m3, m4;
    logic signed [31:0] m3_reg, m4_reg, temp_g_reg, pt3_g_reg;

    // Stage H: output.
    logic signed [31:0] p_sum;
    logic signed [31:0] press_reg, temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[4:0], valid_in};
        end
    end

    always_comb
    begin
        pr_c30 = 44'(coeff.c30) * 44'(ps);
        pr_c21 = 44'(coeff.c21) * 44'(ps);
        pr_c01 = 44'(coeff.c01) * 44'(ts);
        pr_c1  = 40'(coeff.c1) * 40'(ts);
        m1 = WideWidth'(q2a_reg) * WideWidth'(ps_d_reg);
        m2 = WideWidth'(q2b_reg) * WideWidth'(ps_d_reg);
        t100_adj = t100_reg[31] ? t100_reg + 32'sd255 : t100_reg;
        m3 = WideWidth'(q3a_reg) * WideWidth'(ps_f_reg);
        m4 = WideWidth'(q3b_reg) * WideWidth'(ts_f_reg);
        p_sum = (32'(coeff.c00) <<< 8) + m3_reg + pt3_g_reg + m4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pr_c30_reg <= pr_c30[31:0];
            pr_c21_reg <= pr_c21[31:0];
            pr_c01_reg <= pr_c01[31:0];
            pr_c1_reg  <= pr_c1[31:0];
            ps_c_reg   <= ps;
            ts_c_reg   <= ts;

            q2a_reg   <= (32'(coeff.c20) <<< 8) + (pr_c30_reg >>> 8);
            q2b_reg   <= (32'(coeff.c11) <<< 8) + (pr_c21_reg >>> 8);
            t_reg     <= (32'(coeff.c0) <<< 7) + (pr_c1_reg >>> 8);
            pt3_d_reg <= pr_c01_reg >>> 8;
            ps_d_reg  <= ps_c_reg;
            ts_d_reg  <= ts_c_reg;

            m1_reg    <= m1[47:16];
            m2_reg    <= m2[47:16];
            t100_reg  <= t_reg * 32'sd100;
            pt3_e_reg <= pt3_d_reg;
            ps_e_reg  <= ps_d_reg;
            ts_e_reg  <= ts_d_reg;

            q3a_reg    <= (32'(coeff.c10) <<< 8) + m1_reg;
            q3b_reg    <= m2_reg;
            temp_f_reg <= t100_adj >>> 8;
            pt3_f_reg  <= pt3_e_reg;
            ps_f_reg   <= ps_e_reg;
            ts_f_reg   <= ts_e_reg;

            m3_reg     <= m3[47:16];
            m4_reg     <= m4[47:16];
            temp_g_reg <= temp_f_reg;
            pt3_g_reg  <= pt3_f_reg;

            press_reg <= p_sum >>> 8;
            temp_reg  <= temp_g_reg;
        end
    end

    assign valid_out        = valid_reg[5];
    assign comp_pressure    = press_reg;
    assign comp_temperature = temp_reg;

endmodule

>>> sv/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
//
// This block takes one raw pressure and temperature reading pair per transaction and returns
// one compensated result per transaction: pressure in pascal and temperature in hundredths of
// a degree Celsius. It accepts a new transaction in every clock cycle while the output is not
// stalled. Each transaction passes through the oversampling scaler, which divides by the table
// factor with a reciprocal multiply and a one-step correction, and then the polynomial pipeline,
// whose depth is set by the chain of dependent multiplies of the pressure polynomial, each
// followed by an add stage, into the output register. When the output is stalled the whole
// pipeline holds in place, so nothing is lost or repeated; the input stays ready as long as the
// output register is empty or being taken. Calibration registers are written through a plain
// write port and must only change while no transaction is in flight.
module baro_pressure_temp_compensation
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    bpc_in_if.sink                                sample,
    bpc_out_if.source                             result,
    input  logic                                  cfg_we,
    input  logic [bpc_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [bpc_pkg::CfgDataWidth-1:0]      cfg_data
);

    logic [5:0]  osr_select_reg;
    logic [23:0] temp_coeffs_reg;
    logic [19:0] press_offset_reg;
    logic [19:0] press_linear_reg;
    logic [15:0] temp_cross_reg;
    logic [15:0] cross_linear_reg;
    logic [15:0] cross_square_reg;
    logic [31:0] press_high_reg;

    bpc_pkg::coeff_t coeff;

    logic        advance;
    logic [1:0]  scale_valid_reg;
    logic signed [bpc_pkg::ScaledWidth-1:0] ps;
    logic signed [bpc_pkg::ScaledWidth-1:0] ts;

    // Configuration registers; user, not block, keeps them stable while transactions move.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osr_select_reg   <= '0;
            temp_coeffs_reg  <= '0;
            press_offset_reg <= '0;
            press_linear_reg <= '0;
            temp_cross_reg   <= '0;
            cross_linear_reg <= '0;
            cross_square_reg <= '0;
            press_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpc_pkg::REG_OSR_SELECT:   osr_select_reg   <= cfg_data[5:0];
                bpc_pkg::REG_TEMP_COEFFS:  temp_coeffs_reg  <= cfg_data[23:0];
                bpc_pkg::REG_PRESS_OFFSET: press_offset_reg <= cfg_data[19:0];
                bpc_pkg::REG_PRESS_LINEAR: press_linear_reg <= cfg_data[19:0];
                bpc_pkg::REG_TEMP_CROSS:   temp_cross_reg   <= cfg_data[15:0];
                bpc_pkg::REG_CROSS_LINEAR: cross_linear_reg <= cfg_data[15:0];
                bpc_pkg::REG_CROSS_SQUARE: cross_square_reg <= cfg_data[15:0];
                bpc_pkg::REG_PRESS_HIGH:   press_high_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        coeff.osr_select = osr_select_reg;
        coeff.c0  = $signed(temp_coeffs_reg[23:12]);
        coeff.c1  = $signed(temp_coeffs_reg[11:0]);
        coeff.c00 = $signed(press_offset_reg);
        coeff.c10 = $signed(press_linear_reg);
        coeff.c01 = $signed(temp_cross_reg);
        coeff.c11 = $signed(cross_linear_reg);
        coeff.c21 = $signed(cross_square_reg);
        coeff.c20 = $signed(press_high_reg[31:16]);
        coeff.c30 = $signed(press_high_reg[15:0]);
    end

    // The whole pipeline moves together whenever the output register can take a new result.
    assign advance      = !result.valid || result.ready;
    assign sample.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= '0;
        end
        else if (advance)
        begin
            scale_valid_reg <= {scale_valid_reg[0], sample.valid};
        end
    end

    bpc_scaler u_scale_p
    (
        .clk     (clk),
        .advance (advance),
        .raw     (sample.raw_pressure),
        .code    (osr_select_reg[2:0]),
        .scaled  (ps)
    );

    bpc_scaler u_scale_t
    (
        .clk     (clk),
        .advance (advance),
        .raw     (sample.raw_temperature),
        .code    (osr_select_reg[5:3]),
        .scaled  (ts)
    );

    bpc_poly u_poly
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .valid_in         (scale_valid_reg[1]),
        .coeff            (coeff),
        .ps               (ps),
        .ts               (ts),
        .valid_out        (result.valid),
        .comp_pressure    (result.comp_pressure),
        .comp_temperature (result.comp_temperature)
    );

endmodule
